// ----- rtl/rgbac_pkg.sv -----
// Shared types and constants for the RGB555 alpha pixel compositor.
// No dependencies; used by rgbac_mode_dec and the top level.
package rgbac_pkg;

    localparam int PIXEL_W = 16;
    localparam int ALPHA_W = 8;
    localparam int LOW_W   = 7;
    localparam int CFG_W   = 8;
    localparam int INDEX_W = 2;

    // Packed blue/red word: blue at bit 0, red at bit 16.
    localparam int BR_W      = 21;
    localparam int BR_DIFF_W = BR_W + 1;
    localparam int BR_PROD_W = BR_DIFF_W + ALPHA_W + 1;
    localparam int G_W       = 10;
    localparam int G_DIFF_W  = G_W + 1;
    localparam int G_PROD_W  = G_DIFF_W + ALPHA_W + 1;

    localparam int OPAQUE_BIT   = 15;
    localparam int ALPHA_ROUND  = 128;
    localparam int ALPHA_SHIFT  = 8;
    localparam int MASK_BIT     = 7;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_MASK  = 2'd2,
        MODE_BLEND = 2'd3
    } t_mode;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODE     = 2'd0,
        REG_LOW_THR  = 2'd1,
        REG_HIGH_THR = 2'd2,
        REG_UNUSED   = 2'd3
    } t_reg_index;

    typedef struct packed {
        t_mode                mode;
        logic [LOW_W-1:0]     low_thr;
        logic [ALPHA_W-1:0]   high_thr;
    } t_cfg;

    // Outcome of the mode logic: either a blend, or a finished pixel and flag.
    typedef struct packed {
        logic                 blend;
        logic                 write;
        logic [PIXEL_W-1:0]   pixel;
    } t_decision;

endpackage

// ----- rtl/rgbac_mode_dec.sv -----
// Mode decision for the compositor: picks copy, skip or blend per pixel.
// Depends on rgbac_pkg.
module rgbac_mode_dec (
    input  rgbac_pkg::t_cfg                      i_cfg,
    input  logic [rgbac_pkg::PIXEL_W-1:0]        i_src_pixel,
    input  logic [rgbac_pkg::ALPHA_W-1:0]        i_src_alpha,
    input  logic [rgbac_pkg::PIXEL_W-1:0]        i_dst_pixel,
    output rgbac_pkg::t_decision                 o_dec
);
    import rgbac_pkg::*;

    logic [ALPHA_W-1:0] w_low;
    logic [ALPHA_W-1:0] w_blend_max;
    logic [PIXEL_W-1:0] w_opaque;

    assign w_low       = {1'b0, i_cfg.low_thr};
    assign w_blend_max = 8'hFF - w_low;
    assign w_opaque    = PIXEL_W'(1) << OPAQUE_BIT;

    always_comb begin
        o_dec.blend = 1'b0;
        o_dec.write = 1'b0;
        o_dec.pixel = i_dst_pixel;
        unique case (i_cfg.mode)
            MODE_COPY: begin
                o_dec.write = 1'b1;
                o_dec.pixel = i_src_pixel;
            end
            MODE_KEY: begin
                if (i_src_pixel[OPAQUE_BIT]) begin
                    o_dec.write = 1'b1;
                    o_dec.pixel = i_src_pixel;
                end
            end
            MODE_MASK: begin
                o_dec.write = 1'b1;
                o_dec.pixel = (i_src_alpha[MASK_BIT] ? i_src_pixel : '0) | w_opaque;
            end
            MODE_BLEND: begin
                if (i_src_alpha >= w_low) begin
                    if (i_dst_pixel[OPAQUE_BIT] && (i_src_alpha <= w_blend_max)) begin
                        o_dec.blend = 1'b1;
                        o_dec.write = 1'b1;
                    end else if (i_src_alpha >= i_cfg.high_thr) begin
                        o_dec.write = 1'b1;
                        o_dec.pixel = i_src_pixel | w_opaque;
                    end
                end
            end
            default: begin
                o_dec.write = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/rgb555_alpha_pixel_compositor.sv -----
// Top level of the RGB555 alpha pixel compositor: config registers and a
// three-stage pixel pipeline. Depends on rgbac_pkg and rgbac_mode_dec.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+---------------------------------------
//   in       | i_in_valid / o_in_ready     | i_src_pixel, i_src_alpha, i_dst_pixel
//   out      | o_out_valid / i_out_ready   | o_out_pixel, o_write_enable
//   cfg      | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One pixel per clock while the output is not stalled; a result passes through the
// stage 1, stage 2 and stage 3 registers before it is valid at the output.
// Stage 1 decides the mode and forms the packed differences, stage 2 multiplies
// by alpha, stage 3 rounds, adds back and holds the result.
// Reset (synchronous, active low) empties the pipeline and loads mode 3,
// low threshold 8 and high threshold 128.
// Each stage holds while the one after it is full and stalled, so bubbles close up.
module rgb555_alpha_pixel_compositor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rgbac_pkg::INDEX_W-1:0]      i_cfg_index,
    input  logic [rgbac_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rgbac_pkg::PIXEL_W-1:0]      i_src_pixel,
    input  logic [rgbac_pkg::ALPHA_W-1:0]      i_src_alpha,
    input  logic [rgbac_pkg::PIXEL_W-1:0]      i_dst_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rgbac_pkg::PIXEL_W-1:0]      o_out_pixel,
    output logic                               o_write_enable
);
    import rgbac_pkg::*;

    t_cfg r_cfg;

    logic w_rdy1, w_rdy2, w_rdy3;
    logic r_v1, r_v2, r_v3;

    t_decision w_dec;
    logic [BR_W-1:0] w_sbr, w_dbr;

    // Stage 1 registers.
    t_decision                  r1_dec;
    logic [ALPHA_W-1:0]         r1_alpha;
    logic signed [BR_DIFF_W-1:0] r1_diff_br;
    logic signed [G_DIFF_W-1:0]  r1_diff_g;
    logic [PIXEL_W-2:0]         r1_dst;

    // Stage 2 registers.
    t_decision                  r2_dec;
    logic signed [BR_PROD_W-1:0] r2_prod_br;
    logic signed [G_PROD_W-1:0]  r2_prod_g;
    logic [PIXEL_W-2:0]         r2_dst;

    // Stage 3 registers.
    logic [PIXEL_W-1:0]         r_out_pixel;
    logic                       r_write_enable;

    logic signed [31:0] w_br, w_g;
    logic [PIXEL_W-1:0] w_blend_px;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= MODE_BLEND;
            r_cfg.low_thr  <= LOW_W'(8);
            r_cfg.high_thr <= ALPHA_W'(128);
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_MODE:     r_cfg.mode     <= t_mode'(i_cfg_data[1:0]);
                REG_LOW_THR:  r_cfg.low_thr  <= i_cfg_data[LOW_W-1:0];
                REG_HIGH_THR: r_cfg.high_thr <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    assign w_rdy3     = !r_v3 || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    rgbac_mode_dec u_mode_dec (
        .i_cfg       (r_cfg),
        .i_src_pixel (i_src_pixel),
        .i_src_alpha (i_src_alpha),
        .i_dst_pixel (i_dst_pixel),
        .o_dec       (w_dec)
    );

    assign w_sbr = {i_src_pixel[14:10], 11'd0, i_src_pixel[4:0]};
    assign w_dbr = {i_dst_pixel[14:10], 11'd0, i_dst_pixel[4:0]};

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r1_dec     <= w_dec;
            r1_alpha   <= i_src_alpha;
            r1_diff_br <= $signed({1'b0, w_sbr}) - $signed({1'b0, w_dbr});
            r1_diff_g  <= $signed({1'b0, i_src_pixel[9:0] & 10'h3E0})
                        - $signed({1'b0, i_dst_pixel[9:0] & 10'h3E0});
            r1_dst     <= i_dst_pixel[PIXEL_W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            r2_dec     <= r1_dec;
            r2_prod_br <= r1_diff_br * $signed({1'b0, r1_alpha});
            r2_prod_g  <= r1_diff_g * $signed({1'b0, r1_alpha});
            r2_dst     <= r1_dst;
        end
    end

    // Borrows from the rounded blue term may cross into the red field, as in
    // the packed reference arithmetic, so the add-back is done on the whole word.
    always_comb begin
        w_br = $signed({11'd0, r2_dst[14:10], 11'd0, r2_dst[4:0]})
             + ((32'(r2_prod_br) + 32'sd128) >>> ALPHA_SHIFT);
        w_g  = $signed({22'd0, r2_dst[9:5], 5'd0})
             + ((32'(r2_prod_g) + 32'sd128) >>> ALPHA_SHIFT);
        w_blend_px = {1'b1, w_br[20:16], w_g[9:5], w_br[4:0]};
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            r_out_pixel    <= r2_dec.blend ? w_blend_px : r2_dec.pixel;
            r_write_enable <= r2_dec.write;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_out_pixel    = r_out_pixel;
    assign o_write_enable = r_write_enable;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb555_alpha_pixel_compositor: directed corner cases, then
// random pixel streams under several register settings and idle/stall profiles.
// Depends on rgbac_pkg and the compositor RTL.
module testbench;
    import rgbac_pkg::*;

    localparam int CLOCK_LIMIT = 200000;
    localparam int HOLD_CYCLES = 50;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 115;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               we;
    } t_pixel_write;

    class pixel_scoreboard;
        t_mode              mode;
        logic [LOW_W-1:0]   low_thr;
        logic [ALPHA_W-1:0] high_thr;
        t_pixel_write       due_writes[$];
        int                 errors;

        function new();
            mode     = MODE_BLEND;
            low_thr  = 7'd8;
            high_thr = 8'd128;
            errors   = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MODE:     mode = t_mode'(data[1:0]);
                REG_LOW_THR:  low_thr = data[LOW_W-1:0];
                REG_HIGH_THR: high_thr = data;
                default: ;
            endcase
        endfunction

        // Packed lerp: blue at bit 0 and red at bit 16 share one word, so borrows
        // from red into the unused gap bits are expected and harmless.
        function logic [PIXEL_W-1:0] blend_pixel(logic [PIXEL_W-1:0] s, logic [PIXEL_W-1:0] d,
                                                 logic [ALPHA_W-1:0] a);
            longint dbr, sbr, dg, sg, al, br, g;
            dbr = longint'(d[4:0]) | (longint'(d[14:10]) << 16);
            sbr = longint'(s[4:0]) | (longint'(s[14:10]) << 16);
            dg  = longint'(d[9:5]) << 5;
            sg  = longint'(s[9:5]) << 5;
            al  = longint'(a);
            br  = dbr + (((sbr - dbr) * al + ALPHA_ROUND) >>> ALPHA_SHIFT);
            g   = dg + (((sg - dg) * al + ALPHA_ROUND) >>> ALPHA_SHIFT);
            return {1'b1, br[20:16], g[9:5], br[4:0]};
        endfunction

        function t_pixel_write composite(logic [PIXEL_W-1:0] s, logic [ALPHA_W-1:0] a,
                                         logic [PIXEL_W-1:0] d);
            t_pixel_write r;
            r.pixel = d;
            r.we    = 1'b0;
            case (mode)
                MODE_COPY: begin
                    r.pixel = s;
                    r.we    = 1'b1;
                end
                MODE_KEY: begin
                    if (s[OPAQUE_BIT]) begin
                        r.pixel = s;
                        r.we    = 1'b1;
                    end
                end
                MODE_MASK: begin
                    r.pixel = (a[MASK_BIT] ? s : '0);
                    r.pixel[OPAQUE_BIT] = 1'b1;
                    r.we    = 1'b1;
                end
                default: begin
                    if (int'(a) >= int'(low_thr)) begin
                        if (d[OPAQUE_BIT] && int'(a) <= 255 - int'(low_thr)) begin
                            r.pixel = blend_pixel(s, d, a);
                            r.we    = 1'b1;
                        end else if (a >= high_thr) begin
                            r.pixel = s;
                            r.pixel[OPAQUE_BIT] = 1'b1;
                            r.we    = 1'b1;
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [PIXEL_W-1:0] s, logic [ALPHA_W-1:0] a,
                                   logic [PIXEL_W-1:0] d);
            due_writes.push_back(composite(s, a, d));
        endfunction

        function void check_result(logic [PIXEL_W-1:0] pixel, logic we);
            t_pixel_write want;
            if (due_writes.size() == 0) begin
                $error("result with no request pending: out_pixel=%h write_enable=%b", pixel, we);
                errors++;
                return;
            end
            want = due_writes.pop_front();
            if (pixel !== want.pixel) begin
                $error("out_pixel: expected %h, got %h", want.pixel, pixel);
                errors++;
            end
            if (we !== want.we) begin
                $error("write_enable: expected %b, got %b", want.we, we);
                errors++;
            end
        endfunction

        function int pending();
            return due_writes.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [INDEX_W-1:0]   i_cfg_index = REG_MODE;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [PIXEL_W-1:0]   i_src_pixel = '0;
    logic [ALPHA_W-1:0]   i_src_alpha = '0;
    logic [PIXEL_W-1:0]   i_dst_pixel = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PIXEL_W-1:0]   o_out_pixel;
    logic                 o_write_enable;

    pixel_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int cycle_count = 0;

    rgb555_alpha_pixel_compositor uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_src_pixel    (i_src_pixel),
        .i_src_alpha    (i_src_alpha),
        .i_dst_pixel    (i_dst_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("rgb555_alpha_pixel_compositor regression: fail");
            $finish;
        end
    end

    // Result side: checks accepted results and drives ready. A long hold is
    // started whenever hold_seq moves and is counted down here.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_out_pixel, o_write_enable);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Called right after a rising edge; returns at the edge that took the request.
    task automatic send_pixel(input logic [PIXEL_W-1:0] s, input logic [ALPHA_W-1:0] a,
                              input logic [PIXEL_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_src_pixel <= s;
        i_src_alpha <= a;
        i_dst_pixel <= d;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_request(s, a, d);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input int mode, input int low, input int high);
        wait_drained();
        write_reg(REG_MODE, CFG_W'(mode));
        write_reg(REG_LOW_THR, CFG_W'(low));
        write_reg(REG_HIGH_THR, CFG_W'(high));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    // Alpha values cluster around the thresholds, where the mode decisions flip.
    function automatic logic [ALPHA_W-1:0] random_alpha(int low, int high);
        int v;
        case ($urandom_range(0, 5))
            0: v = low - 1 + $urandom_range(0, 2);
            1: v = 254 - low + $urandom_range(0, 2);
            2: v = high - 1 + $urandom_range(0, 2);
            3: v = $urandom_range(0, 1) ? 255 : 0;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return ALPHA_W'(v);
    endfunction

    initial begin
        int mode_tab[PHASES];
        int low_tab[PHASES];
        int high_tab[PHASES];
        int idle_tab[4];
        int stall_tab[4];
        int low;
        int high;
        mode_tab  = '{3, 0, 3, 1, 3, 2, 3, 3, 3, 3};
        low_tab   = '{8, 0, 127, 64, 0, 127, 0, 127, 8, 8};
        high_tab  = '{128, 0, 255, 200, 0, 255, 255, 0, 128, 128};
        idle_tab  = '{0, 63, 0, 15};
        stall_tab = '{0, 0, 63, 15};
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: blend with low 8, high 128.
        send_pixel(16'h1234, 8'd0, 16'h8000);
        send_pixel(16'hFFFF, 8'd7, 16'h8000);
        send_pixel(16'hFFFF, 8'd8, 16'h8000);
        send_pixel(16'h7FFF, 8'd247, 16'h8000);
        send_pixel(16'h0000, 8'd248, 16'hFFFF);
        send_pixel(16'h2A55, 8'd255, 16'h7FFF);
        send_pixel(16'h5555, 8'd100, 16'h1234);
        send_pixel(16'hFFFF, 8'd128, 16'h8000);
        send_pixel(16'h0000, 8'd200, 16'hFFFF);
        send_pixel(16'h7C1F, 8'd129, 16'h83E0);

        set_config(MODE_COPY, 8, 128);
        send_pixel(16'hFFFF, 8'd0, 16'h0000);
        send_pixel(16'h0000, 8'd255, 16'hFFFF);
        set_config(MODE_KEY, 8, 128);
        send_pixel(16'h8123, 8'd0, 16'h4321);
        send_pixel(16'h7FFF, 8'd255, 16'h8000);
        set_config(MODE_MASK, 8, 128);
        send_pixel(16'h1234, 8'h80, 16'hFFFF);
        send_pixel(16'hFFFF, 8'h7F, 16'h0000);

        // Overlapping thresholds: the blend test wins over the copy fallback.
        set_config(MODE_BLEND, 127, 0);
        send_pixel(16'h7FFF, 8'd126, 16'h8000);
        send_pixel(16'h7FFF, 8'd127, 16'h8000);
        send_pixel(16'h1F00, 8'd129, 16'h8000);
        set_config(MODE_BLEND, 0, 255);
        send_pixel(16'hFFFF, 8'd0, 16'h8421);
        send_pixel(16'h0000, 8'd255, 16'hFFFF);
        send_pixel(16'h1234, 8'd254, 16'h7FFF);
        send_pixel(16'h1234, 8'd255, 16'h7FFF);

        // The spare index must not disturb the live registers.
        wait_drained();
        write_reg(REG_UNUSED, 8'h5A);
        i_cfg_we <= 1'b0;
        send_pixel(16'h4210, 8'd64, 16'hC631);

        for (int p = 0; p < PHASES; p++) begin
            low  = low_tab[p];
            high = high_tab[p];
            if (p == 8) begin
                low  = $urandom_range(0, 127);
                high = $urandom_range(0, 255);
            end else if (p == 9) begin
                low  = $urandom_range(0, 40);
                high = $urandom_range(0, 255);
            end
            set_config(mode_tab[p], low, high);
            send_idle_pct = idle_tab[p % 4];
            stall_pct    <= stall_tab[p % 4];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 20)
                    hold_seq <= hold_seq + 1;
                send_pixel(random_pixel(), random_alpha(low, high), random_pixel());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("rgb555_alpha_pixel_compositor regression: pass");
        else
            $display("rgb555_alpha_pixel_compositor regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rgbac_pkg.sv
rtl/rgbac_mode_dec.sv
rtl/rgb555_alpha_pixel_compositor.sv
tb/testbench.sv
